/* hdl/lqt_pkg.sv */
// lqt_pkg: shared types, constants and arithmetic helpers of the link quality tracker
// used by lqt_front, lqt_back and link_quality_tracker; no dependencies
package lqt_pkg;

    localparam int LINKS_DEF       = 16;
    localparam int WINDOW_DEF      = 32;
    localparam int COST_BROKEN_DEF = 255;
    localparam int MAX_RES         = 16;

    localparam logic [7:0]  LQ_FULL    = 8'd255;
    localparam logic [15:0] TOTAL_INIT = 16'd3;
    localparam logic [15:0] GAP_LIMIT  = 16'd256;

    // request codes
    localparam logic [1:0] REQ_HELLO   = 2'd0;
    localparam logic [1:0] REQ_LOST    = 2'd1;
    localparam logic [1:0] REQ_FOREIGN = 2'd2;
    localparam logic [1:0] REQ_TICK    = 2'd3;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [3:0]  link_index;
        logic [15:0] seq_number;
        logic        foreign_present;
        logic [7:0]  foreign_lq;
        logic [7:0]  cca_load;
        logic [7:0]  nav_load;
    } req_t;

    typedef struct packed {
        logic [3:0]  out_link;
        logic [7:0]  link_cost;
        logic        cost_updated;
        logic        any_change;
        logic        duplicate;
        logic [8:0]  seq_gap;
        logic [15:0] slot_received;
        logic [15:0] slot_total;
        logic [7:0]  missed_count;
        logic        last;
    } rsp_t;

    typedef enum logic [2:0] {
        OP_HELLO,
        OP_LOST,
        OP_FOREIGN,
        OP_TICK,
        OP_IGNORE
    } op_kind_t;

    // classified word passed from front to back
    typedef struct packed {
        op_kind_t    kind;
        logic [3:0]  link;
        logic [15:0] seq;
        logic [7:0]  fq;
        logic [7:0]  load;
    } op_t;

    // back status seen by the front
    typedef struct packed {
        logic take;
        logic clearing;
    } back_stat_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_APPLY,
        ST_ADVANCE,
        ST_HYST,
        ST_EMIT
    } back_state_t;

    // x / 10 for 8-bit x by reciprocal multiply
    function automatic logic [7:0] div10(input logic [7:0] x);
        logic [15:0] p;
        p = 16'(x) * 16'd205;
        return 8'(p >> 11);
    endfunction

    // 10 percent hysteresis test
    function automatic logic moved(input logic [7:0] sm, input logic [7:0] cur);
        logic [7:0] tenth;
        tenth = div10(sm);
        if (sm < cur)
            return (cur == LQ_FULL) || ((cur - sm) > tenth);
        else if (sm > cur)
            return (sm - cur) > tenth;
        else
            return 1'b0;
    endfunction

    // (lq + nlq) / 2 clamped to 1..broken
    function automatic logic [7:0] cost_of(input logic [7:0] lq, input logic [7:0] nlq,
                                           input logic [7:0] broken);
        logic [8:0] s;
        logic [7:0] c;
        s = 9'(lq) + 9'(nlq);
        c = s[8:1];
        if (c > broken)
            c = broken;
        if (c == 8'd0)
            c = 8'd1;
        return c;
    endfunction

endpackage

/* hdl/lqt_front.sv */
// lqt_front: accepts commands, classifies them and queues them for the back end
// depends on lqt_pkg
module lqt_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  lqt_pkg::req_t     req,
    input  logic [4:0]        n_links,
    input  lqt_pkg::back_stat_t stat,
    output logic              q_valid,
    output lqt_pkg::op_t      q_op
);
    import lqt_pkg::*;

    op_t        q0_reg, q0_next, q1_reg, q1_next, cls;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;
    logic [7:0] load;

    assign busy    = (cnt_reg == 2'd2) || stat.clearing;
    assign push    = start && !busy;
    assign pop     = stat.take;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_op    = q0_reg;

    // classify the incoming word
    always_comb
    begin
        load      = (req.cca_load > req.nav_load) ? req.cca_load : req.nav_load;
        cls.link  = req.link_index;
        cls.seq   = req.seq_number;
        cls.fq    = req.foreign_present ? req.foreign_lq : 8'd0;
        cls.load  = load;
        cls.kind  = OP_IGNORE;
        if (req.req_type == REQ_TICK)
            cls.kind = OP_TICK;
        else if ({1'b0, req.link_index} < n_links)
        begin
            unique case (req.req_type)
                REQ_HELLO:   cls.kind = OP_HELLO;
                REQ_LOST:    cls.kind = OP_LOST;
                REQ_FOREIGN: cls.kind = OP_FOREIGN;
                default:     cls.kind = OP_IGNORE;
            endcase
        end
    end

    // two-entry queue
    always_comb
    begin
        q0_next  = q0_reg;
        q1_next  = q1_reg;
        cnt_next = cnt_reg;
        case ({push, pop})
            2'b10:
            begin
                if (cnt_reg == 2'd0)
                    q0_next = cls;
                else
                    q1_next = cls;
                cnt_next = cnt_reg + 2'd1;
            end
            2'b01:
            begin
                q0_next  = q1_reg;
                cnt_next = cnt_reg - 2'd1;
            end
            2'b11:
            begin
                if (cnt_reg == 2'd1)
                    q0_next = cls;
                else
                begin
                    q0_next = q1_reg;
                    q1_next = cls;
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

endmodule

/* hdl/lqt_back.sv */
// lqt_back: executes queued words against the link table and window memory
// depends on lqt_pkg
module lqt_back #(
    parameter int LINKS       = lqt_pkg::LINKS_DEF,
    parameter int WINDOW      = lqt_pkg::WINDOW_DEF,
    parameter int COST_BROKEN = lqt_pkg::COST_BROKEN_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  lqt_pkg::op_t        q_op,
    input  logic [4:0]          n_links,
    output lqt_pkg::back_stat_t stat,
    output lqt_pkg::rsp_t       result,
    output logic                strobe
);
    import lqt_pkg::*;

    localparam int LW    = (LINKS > 1) ? $clog2(LINKS) : 1;
    localparam int SW    = $clog2(WINDOW);
    localparam int DEPTH = LINKS * WINDOW;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] WIN_A  = AW'(WINDOW);
    localparam logic [AW-1:0] LAST_A = AW'(DEPTH - 1);
    localparam logic [SW-1:0] LAST_S = SW'(WINDOW - 1);
    localparam logic [7:0]    BROKEN = 8'(COST_BROKEN);

    back_state_t state_reg, state_next;
    op_t         op_reg;
    logic [LW-1:0] idx_reg, idx_next;
    logic [AW-1:0] clr_reg;
    logic          any_reg, any_next;
    logic [LINKS-1:0] upd_reg;
    logic [7:0]    sa_reg;
    rsp_t          res_reg, res_next;
    logic          strobe_reg, strobe_next;

    logic [15:0]   last_seq_reg [LINKS];
    logic [SW-1:0] ptr_reg      [LINKS];
    logic [7:0]    missed_reg   [LINKS];
    logic [7:0]    own_reg      [LINKS];
    logic [7:0]    nbr_reg      [LINKS];
    logic [7:0]    sown_reg     [LINKS];
    logic [7:0]    snbr_reg     [LINKS];
    logic [7:0]    cost_reg     [LINKS];

    logic [31:0]   mem [DEPTH];
    logic [31:0]   rdata_reg;
    logic [AW-1:0] raddr, waddr;
    logic [31:0]   wdata;
    logic          we;

    logic [LW-1:0] lidx;
    logic          take, last_tick;
    logic          dup;
    logic [15:0]   gap16;
    logic [8:0]    gap;
    logic [16:0]   rsum, tsum;
    logic [15:0]   rsat, tsat;
    logic [8:0]    avg_sum;
    logic [7:0]    avg;
    logic [SW-1:0] pnew;
    logic          hit, refr;
    logic [7:0]    new_cost;

    assign take          = (state_reg == ST_IDLE) && q_valid;
    assign stat.take     = take;
    assign stat.clearing = (state_reg == ST_CLEAR);
    assign lidx          = LW'(q_op.link);
    assign last_tick     = (32'(idx_reg) + 32'd1) == 32'(n_links);
    assign result        = res_reg;
    assign strobe        = strobe_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
                if (clr_reg == LAST_A)
                    state_next = ST_IDLE;
            ST_IDLE:
                if (q_valid)
                begin
                    unique case (q_op.kind)
                        OP_HELLO, OP_LOST, OP_FOREIGN: state_next = ST_APPLY;
                        OP_TICK:
                            if (n_links != 5'd0)
                                state_next = ST_ADVANCE;
                        default: state_next = ST_IDLE;
                    endcase
                end
            ST_APPLY:
                state_next = ST_IDLE;
            ST_ADVANCE:
                if (last_tick)
                    state_next = ST_HYST;
            ST_HYST:
                if (last_tick)
                    state_next = ST_EMIT;
            ST_EMIT:
                if (last_tick)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath values
    always_comb
    begin
        dup      = (op_reg.seq == last_seq_reg[idx_reg]);
        gap16    = op_reg.seq - last_seq_reg[idx_reg];
        gap      = (gap16 > GAP_LIMIT) ? 9'd1 : gap16[8:0];
        rsum     = {1'b0, rdata_reg[31:16]} + 17'd1;
        tsum     = {1'b0, rdata_reg[15:0]} + 17'(gap);
        rsat     = rsum[16] ? 16'hFFFF : rsum[15:0];
        tsat     = tsum[16] ? 16'hFFFF : tsum[15:0];
        avg_sum  = 9'(sa_reg) + 9'(op_reg.load);
        avg      = (avg_sum[8:1] == 8'd0) ? 8'd1 : avg_sum[8:1];
        pnew     = (ptr_reg[idx_reg] == LAST_S) ? '0 : ptr_reg[idx_reg] + SW'(1);
        hit      = moved(sown_reg[idx_reg], own_reg[idx_reg])
                   || moved(snbr_reg[idx_reg], nbr_reg[idx_reg]);
        refr     = any_reg
                   && !((sown_reg[idx_reg] == LQ_FULL) && (snbr_reg[idx_reg] == LQ_FULL))
                   && !((sown_reg[idx_reg] == own_reg[idx_reg])
                        && (snbr_reg[idx_reg] == nbr_reg[idx_reg]));
        new_cost = cost_of(own_reg[idx_reg], nbr_reg[idx_reg], BROKEN);
    end

    // outputs of each state
    always_comb
    begin
        idx_next    = idx_reg;
        any_next    = any_reg;
        res_next    = res_reg;
        strobe_next = 1'b0;
        raddr       = AW'(lidx) * WIN_A + AW'(ptr_reg[lidx]);
        waddr       = AW'(idx_reg) * WIN_A + AW'(ptr_reg[idx_reg]);
        wdata       = {rsat, tsat};
        we          = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                waddr = clr_reg;
                wdata = {16'd0, TOTAL_INIT};
                we    = 1'b1;
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    idx_next = (q_op.kind == OP_TICK) ? '0 : lidx;
                    any_next = 1'b0;
                    if (q_op.kind == OP_IGNORE)
                    begin
                        res_next          = '0;
                        res_next.out_link = q_op.link;
                        res_next.last     = 1'b1;
                        strobe_next       = 1'b1;
                    end
                end
            end
            ST_APPLY:
            begin
                res_next               = '0;
                res_next.out_link      = op_reg.link;
                res_next.link_cost     = cost_reg[idx_reg];
                res_next.slot_received = rdata_reg[31:16];
                res_next.slot_total    = rdata_reg[15:0];
                res_next.missed_count  = missed_reg[idx_reg];
                res_next.last          = 1'b1;
                strobe_next            = 1'b1;
                unique case (op_reg.kind)
                    OP_HELLO:
                    begin
                        if (dup)
                            res_next.duplicate = 1'b1;
                        else
                        begin
                            we                     = 1'b1;
                            res_next.seq_gap       = gap;
                            res_next.slot_received = rsat;
                            res_next.slot_total    = tsat;
                            res_next.missed_count  = 8'd0;
                        end
                    end
                    OP_LOST:
                    begin
                        if (missed_reg[idx_reg] != 8'hFF)
                            res_next.missed_count = missed_reg[idx_reg] + 8'd1;
                    end
                    default:
                    begin
                        res_next.missed_count = missed_reg[idx_reg];
                    end
                endcase
            end
            ST_ADVANCE:
            begin
                waddr    = AW'(idx_reg) * WIN_A + AW'(pnew);
                wdata    = 32'd0;
                we       = 1'b1;
                idx_next = last_tick ? '0 : idx_reg + LW'(1);
            end
            ST_HYST:
            begin
                if (hit)
                    any_next = 1'b1;
                idx_next = last_tick ? '0 : idx_reg + LW'(1);
            end
            ST_EMIT:
            begin
                res_next              = '0;
                res_next.out_link     = 4'(idx_reg);
                res_next.link_cost    = refr ? new_cost : cost_reg[idx_reg];
                res_next.cost_updated = upd_reg[idx_reg] || refr;
                res_next.any_change   = any_reg;
                res_next.missed_count = missed_reg[idx_reg];
                res_next.last         = last_tick;
                strobe_next           = 1'b1;
                idx_next              = idx_reg + LW'(1);
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    // control and link table registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            idx_reg    <= '0;
            clr_reg    <= '0;
            any_reg    <= 1'b0;
            upd_reg    <= '0;
            sa_reg     <= 8'd0;
            strobe_reg <= 1'b0;
            for (int i = 0; i < LINKS; i++)
            begin
                last_seq_reg[i] <= 16'd0;
                ptr_reg[i]      <= '0;
                missed_reg[i]   <= 8'd0;
                own_reg[i]      <= 8'd0;
                nbr_reg[i]      <= 8'd0;
                sown_reg[i]     <= 8'd0;
                snbr_reg[i]     <= 8'd0;
                cost_reg[i]     <= 8'd0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            any_reg    <= any_next;
            strobe_reg <= strobe_next;
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + AW'(1);
            if (state_reg == ST_APPLY)
            begin
                if (op_reg.kind == OP_HELLO && !dup)
                begin
                    last_seq_reg[idx_reg] <= op_reg.seq;
                    missed_reg[idx_reg]   <= 8'd0;
                end
                if (op_reg.kind == OP_LOST && missed_reg[idx_reg] != 8'hFF)
                    missed_reg[idx_reg] <= missed_reg[idx_reg] + 8'd1;
                if (op_reg.kind == OP_FOREIGN)
                    nbr_reg[idx_reg] <= op_reg.fq;
            end
            if (state_reg == ST_ADVANCE)
            begin
                sa_reg           <= avg;
                own_reg[idx_reg] <= avg;
                ptr_reg[idx_reg] <= pnew;
                upd_reg[idx_reg] <= 1'b0;
            end
            if ((state_reg == ST_HYST && hit) || (state_reg == ST_EMIT && refr))
            begin
                sown_reg[idx_reg] <= own_reg[idx_reg];
                snbr_reg[idx_reg] <= nbr_reg[idx_reg];
                cost_reg[idx_reg] <= new_cost;
                upd_reg[idx_reg]  <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (take)
            op_reg <= q_op;
    end

    // window memory
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

endmodule

/* hdl/link_quality_tracker.sv */
// link_quality_tracker: top level joining front end, back end and the config register
// depends on lqt_pkg, lqt_front, lqt_back
//
// Usage. A command word (req) is taken at a rising edge with start high and busy low.
// The front classifies it into a two-entry queue; the back executes queued words one
// at a time. Every result word appears on result for exactly one cycle with strobe
// high; the receiver cannot hold it off. Hello, loss, foreign and unused-link words
// give one result each; a tick gives one result per link in use, last marking the end.
// Steps: a hello, loss or foreign word is a window memory read, then an update; an
// unused-link word is answered from idle; a tick runs advance, hysteresis and emit
// passes over the N links in use, one link per cycle. The result word and strobe are
// registered and appear in the cycle after the cycle that computes them. The back
// end takes no new word from the queue until it is back in idle.
// The configuration channel (cfg_valid, cfg_ready, cfg_data) writes the count of
// links in use; cfg_ready is always high, write only while the block is idle.
// After reset the back runs a clearing pass over all LINKS*WINDOW window memory
// words (512 at default sizes), with busy held high.
module link_quality_tracker #(
    parameter int LINKS       = lqt_pkg::LINKS_DEF,
    parameter int WINDOW      = lqt_pkg::WINDOW_DEF,
    parameter int COST_BROKEN = lqt_pkg::COST_BROKEN_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  lqt_pkg::req_t req,
    output lqt_pkg::rsp_t result,
    output logic          strobe,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [4:0]    cfg_data
);
    import lqt_pkg::*;

    localparam int LIM = (LINKS < MAX_RES) ? LINKS : MAX_RES;

    logic [4:0]  active_reg;
    logic [4:0]  n_links;
    logic        q_valid;
    op_t         q_op;
    back_stat_t  stat;

    assign cfg_ready = 1'b1;
    assign n_links   = (active_reg > 5'(LIM)) ? 5'(LIM) : active_reg;

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            active_reg <= 5'd0;
        else if (cfg_valid && cfg_ready)
            active_reg <= cfg_data;
    end

    lqt_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .req     (req),
        .n_links (n_links),
        .stat    (stat),
        .q_valid (q_valid),
        .q_op    (q_op)
    );

    lqt_back #(
        .LINKS       (LINKS),
        .WINDOW      (WINDOW),
        .COST_BROKEN (COST_BROKEN)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_op    (q_op),
        .n_links (n_links),
        .stat    (stat),
        .result  (result),
        .strobe  (strobe)
    );

`ifndef SYNTHESIS
    // no result word during the clearing pass
    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        stat.clearing |=> !strobe)
        else $error("result during clearing pass");

    // a refreshed cost implies some link passed hysteresis
    a_upd_needs_change: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.cost_updated |-> result.any_change && result.link_cost != 8'd0)
        else $error("cost refresh without change");

    // duplicates carry no gap
    a_dup_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.duplicate |-> result.seq_gap == 9'd0)
        else $error("duplicate with nonzero gap");

    // queue never taken while busy from clearing
    a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        stat.clearing |-> !stat.take && busy)
        else $error("queue taken during clearing");
`endif

endmodule
